// ===== rtl/core/fvn_pkg.sv =====
// Package for the fractal value noise block: shared types, fixed widths,
// hash prime rows, config register indexes and the cosine weight builder.
// No dependencies.
package fvn_pkg;

    localparam int COORD_W     = 32;
    localparam int OUT_W       = 20;
    localparam int VAL_W       = 18;
    localparam int WEIGHT_W    = 17;
    localparam int OCT_NW      = 5;
    localparam int SET_NW      = 4;
    localparam int ROW_W       = 4;
    localparam int STORED_SETS = 10;
    localparam int GRID_N      = 16;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_OCTAVE_COUNT    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_AMPLITUDE_RATIO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRIME_SET_START = 2'd2;

    localparam logic [3:0]  RST_OCTAVE_COUNT    = 4'd7;
    localparam logic [15:0] RST_AMPLITUDE_RATIO = 16'd16384;
    localparam logic [3:0]  RST_PRIME_SET_START = 4'd0;

    localparam int OUT_MAX = 524287;
    localparam int OUT_MIN = -524288;

    typedef logic signed [VAL_W-1:0] val_t;
    typedef logic [WEIGHT_W-1:0]     weight_t;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [OCT_NW-1:0]  oct_n;
        logic [SET_NW-1:0]  set0;
    } job_t;

    typedef struct packed {
        logic [3:0] pos;
        logic       last;
        logic       final_oct;
        weight_t    wx;
        weight_t    wy;
    } hash_tag_t;

    localparam logic [31:0] PRIME_ROWS [STORED_SETS][3] = '{
        '{32'd995615039, 32'd600173719, 32'd701464987},
        '{32'd831731269, 32'd162318869, 32'd136250887},
        '{32'd174329291, 32'd946737083, 32'd245679977},
        '{32'd362489573, 32'd795918041, 32'd350777237},
        '{32'd457025711, 32'd880830799, 32'd909678923},
        '{32'd787070341, 32'd177340217, 32'd593320781},
        '{32'd405493717, 32'd291031019, 32'd391950901},
        '{32'd458904767, 32'd676625681, 32'd424452397},
        '{32'd531736441, 32'd939683957, 32'd810651871},
        '{32'd997169939, 32'd842027887, 32'd423882827}
    };

    // (1 - cos) / 2 from the even Taylor series in Q30, rounded to Q16
    function automatic longint half_weight(input longint idx, input int bits);
        longint unsigned th;
        longint unsigned p2;
        longint unsigned p4;
        longint unsigned p6;
        longint unsigned p8;
        longint unsigned p10;
        longint          v;
        th  = (64'd3373259426 * longint'(idx)) >> bits;
        p2  = (th * th) >> 30;
        p4  = (p2 * p2) >> 30;
        p6  = (p4 * p2) >> 30;
        p8  = (p6 * p2) >> 30;
        p10 = (p8 * p2) >> 30;
        v = longint'(p2 / 2) - longint'(p4 / 24) + longint'(p6 / 720)
            - longint'(p8 / 40320) + longint'(p10 / 3628800);
        if (v < 0)
            v = 0;
        return (v + 16384) >>> 15;
    endfunction

    function automatic weight_t cos_weight(input int idx, input int bits);
        longint full;
        full = longint'(1) << bits;
        if (longint'(idx) <= (full >> 1))
            return WEIGHT_W'(half_weight(longint'(idx), bits));
        return WEIGHT_W'(65536 - half_weight(full - longint'(idx), bits));
    endfunction

endpackage

// ===== rtl/core/fvn_if.sv =====
// Valid/ready channel interfaces for sample points and noise results.
// Depends on nothing.
interface fvn_sample_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] x_coord;
    logic signed [31:0] y_coord;

    modport source (output valid, output x_coord, output y_coord, input ready);
    modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface fvn_result_if;
    logic               valid;
    logic               ready;
    logic signed [19:0] noise_value;

    modport source (output valid, output noise_value, input ready);
    modport sink   (input valid, input noise_value, output ready);
endinterface

// ===== rtl/core/fvn_front.sv =====
// Front end: accepts sample items, resolves octave count and first prime set,
// and holds them in a two-entry queue for the back end. Uses fvn_pkg, fvn_if.
module fvn_front #(
    parameter int MAX_OCTAVES = 8,
    parameter int PRIME_SETS  = 10
) (
    input  logic                              clk,
    input  logic                              rst_n,
    fvn_sample_if.sink                        sample,
    input  logic [3:0]                        octave_count,
    input  logic [3:0]                        prime_set_start,
    output logic                              q_valid,
    output fvn_pkg::job_t                     q_item,
    input  logic                              q_pop
);
    import fvn_pkg::*;

    logic [SET_NW-1:0] set_lut [16];
    job_t              q_mem_reg [2];
    logic              wr_ptr_reg, wr_ptr_next;
    logic              rd_ptr_reg, rd_ptr_next;
    logic [1:0]        count_reg, count_next;
    logic              push;
    logic              pop;
    job_t              new_job;

    for (genvar g = 0; g < 16; g++) begin : g_set
        assign set_lut[g] = SET_NW'(g % PRIME_SETS);
    end

    always_comb
    begin
        new_job.x     = sample.x_coord;
        new_job.y     = sample.y_coord;
        new_job.set0  = set_lut[prime_set_start];
        if (OCT_NW'(octave_count) > OCT_NW'(MAX_OCTAVES))
            new_job.oct_n = OCT_NW'(MAX_OCTAVES);
        else
            new_job.oct_n = OCT_NW'(octave_count);
    end

    assign sample.ready = (count_reg != 2'd2);
    assign push         = sample.valid && sample.ready;
    assign q_valid      = (count_reg != 2'd0);
    assign pop          = q_pop && q_valid;
    assign q_item       = q_mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
            q_mem_reg[wr_ptr_reg] <= new_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/core/fvn_hash.sv =====
// Four-stage lattice hash pipeline, one lattice point per cycle, giving the
// Q16 lattice value. Sideband tags travel alongside. Uses fvn_pkg.
module fvn_hash (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    input  logic [31:0]           xi,
    input  logic [31:0]           yi,
    input  logic [3:0]            row,
    input  fvn_pkg::hash_tag_t    in_tag,
    output logic                  out_valid,
    output fvn_pkg::val_t         value,
    output fvn_pkg::hash_tag_t    out_tag
);
    import fvn_pkg::*;

    logic [31:0]     n0;
    logic [31:0]     s1_n_reg;
    logic [ROW_W-1:0] s1_row_reg;
    hash_tag_t       s1_tag_reg;
    logic            s1_valid_reg;

    logic [31:0]     s2_n_reg;
    logic [31:0]     s2_nn_reg;
    logic [ROW_W-1:0] s2_row_reg;
    hash_tag_t       s2_tag_reg;
    logic            s2_valid_reg;

    logic [31:0]     s3_n_reg;
    logic [31:0]     s3_m_reg;
    logic [ROW_W-1:0] s3_row_reg;
    hash_tag_t       s3_tag_reg;
    logic            s3_valid_reg;

    logic [31:0]     t_full;
    val_t            s4_val_reg;
    hash_tag_t       s4_tag_reg;
    logic            s4_valid_reg;

    assign n0     = xi + yi * 32'd57;
    assign t_full = (s3_n_reg * s3_m_reg + PRIME_ROWS[s3_row_reg][2]) & 32'h7fff_ffff;

    always_ff @(posedge clk)
    begin
        s1_n_reg   <= (n0 << 13) ^ n0;
        s1_row_reg <= row;
        s1_tag_reg <= in_tag;

        s2_n_reg   <= s1_n_reg;
        s2_nn_reg  <= s1_n_reg * s1_n_reg;
        s2_row_reg <= s1_row_reg;
        s2_tag_reg <= s1_tag_reg;

        s3_n_reg   <= s2_n_reg;
        s3_m_reg   <= s2_nn_reg * PRIME_ROWS[s2_row_reg][0] + PRIME_ROWS[s2_row_reg][1];
        s3_row_reg <= s2_row_reg;
        s3_tag_reg <= s2_tag_reg;

        s4_val_reg <= VAL_W'(65536) - VAL_W'(t_full >> 14);
        s4_tag_reg <= s3_tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    assign out_valid = s4_valid_reg;
    assign value     = s4_val_reg;
    assign out_tag   = s4_tag_reg;

endmodule

// ===== rtl/core/fvn_back.sv =====
// Back end: octave sequencer feeding the hash pipeline, lattice grid, smoothing,
// cosine blend, amplitude weighting, accumulation and result register.
// Uses fvn_pkg, fvn_if, fvn_hash.
module fvn_back #(
    parameter int MAX_OCTAVES    = 8,
    parameter int PRIME_SETS     = 10,
    parameter int COS_TABLE_BITS = 8
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  fvn_pkg::job_t   q_item,
    output logic            q_pop,
    input  logic [15:0]     amplitude_ratio,
    fvn_result_if.source    result
);
    import fvn_pkg::*;

    localparam int TBL_N  = 1 << COS_TABLE_BITS;
    localparam int AMP_W  = 16 + MAX_OCTAVES;
    localparam int PROD_W = VAL_W + AMP_W + 1;
    localparam int ACC_W  = PROD_W + 4;
    localparam int R_W    = ACC_W - 15;
    localparam logic signed [R_W-1:0] R_MAX = R_W'(OUT_MAX);
    localparam logic signed [R_W-1:0] R_MIN = R_W'(OUT_MIN);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_SETUP = 3'd1;
    localparam logic [2:0] ST_ISSUE = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_OUT   = 3'd4;

    weight_t cos_lut [TBL_N];
    for (genvar g = 0; g < TBL_N; g++) begin : g_cos
        assign cos_lut[g] = cos_weight(g, COS_TABLE_BITS);
    end

    logic [2:0]         state_reg, state_next;
    logic [COORD_W-1:0] x_reg, y_reg;
    logic [OCT_NW-1:0]  n_reg;
    logic [OCT_NW-1:0]  k_reg;
    logic [SET_NW-1:0]  set_reg;
    logic [3:0]         j_reg;
    logic [31:0]        cx_reg, cy_reg;
    weight_t            wx_reg, wy_reg;

    // octave setup
    logic [OCT_NW-1:0]  nm1k;
    logic [5:0]         sh;
    logic [5:0]         fsh;
    logic [31:0]        mag_x, mag_y, ip_x, ip_y, fr_x, fr_y;
    logic [ROW_W-1:0]   row;

    // hash port
    logic               h_in_valid;
    logic [31:0]        h_xi, h_yi;
    hash_tag_t          h_in_tag;
    logic               h_valid;
    val_t               h_value;
    hash_tag_t          h_tag;

    // finisher
    val_t               grid_reg [GRID_N];
    logic               go_reg;
    weight_t            fwx_reg, fwy_reg;
    logic               fin_reg;
    val_t               sm_reg [4];
    logic               f1_valid_reg;
    val_t               bx0_reg, bx1_reg;
    logic               f2_valid_reg;
    val_t               v_reg;
    logic               f3_valid_reg;
    logic [AMP_W-1:0]   amp_reg;
    logic [AMP_W+15:0]  amp_mul;
    logic signed [PROD_W-1:0] prod_reg;
    logic               f4_valid_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic               done_reg;
    logic               start;

    logic signed [R_W-1:0]    r_full;
    logic signed [OUT_W-1:0]  r_sat;
    logic                     out_valid_reg;
    logic signed [OUT_W-1:0]  out_data_reg;
    logic                     out_load;

    function automatic val_t smooth(input val_t g [GRID_N], input int a, input int b);
        logic signed [21:0] c;
        logic signed [21:0] s;
        logic signed [21:0] sum;
        c = 22'(g[b*4 + a]) + 22'(g[b*4 + a + 2]) + 22'(g[(b+2)*4 + a])
            + 22'(g[(b+2)*4 + a + 2]);
        s = 22'(g[b*4 + a + 1]) + 22'(g[(b+2)*4 + a + 1]) + 22'(g[(b+1)*4 + a])
            + 22'(g[(b+1)*4 + a + 2]);
        sum = c + (s <<< 1) + (22'(g[(b+1)*4 + a + 1]) <<< 2);
        return VAL_W'(sum >>> 4);
    endfunction

    function automatic val_t blend(input val_t a, input val_t b, input weight_t w);
        logic signed [18:0] d;
        logic signed [36:0] p;
        logic signed [18:0] r;
        d = 19'(b) - 19'(a);
        p = 37'(d) * 37'($signed({1'b0, w}));
        r = 19'(a) + 19'(p >>> 16);
        return VAL_W'(r);
    endfunction

    // split of the current point for octave k
    always_comb
    begin
        nm1k  = n_reg - OCT_NW'(1) - k_reg;
        sh    = 6'd16 + 6'(nm1k);
        fsh   = 6'(16 - COS_TABLE_BITS) + 6'(nm1k);
        mag_x = x_reg[31] ? (~x_reg + 32'd1) : x_reg;
        mag_y = y_reg[31] ? (~y_reg + 32'd1) : y_reg;
        ip_x  = mag_x >> sh;
        ip_y  = mag_y >> sh;
        fr_x  = mag_x >> fsh;
        fr_y  = mag_y >> fsh;
        row   = (set_reg >= SET_NW'(STORED_SETS)) ? ROW_W'(set_reg - SET_NW'(STORED_SETS))
                                                  : ROW_W'(set_reg);
    end

    assign start = (state_reg == ST_IDLE) && q_valid;
    assign q_pop = start;

    always_comb
    begin
        h_in_valid         = (state_reg == ST_ISSUE);
        h_xi               = cx_reg - 32'd1 + 32'(j_reg[1:0]);
        h_yi               = cy_reg - 32'd1 + 32'(j_reg[3:2]);
        h_in_tag.pos       = j_reg;
        h_in_tag.last      = (j_reg == 4'd15);
        h_in_tag.final_oct = (k_reg == n_reg - OCT_NW'(1));
        h_in_tag.wx        = wx_reg;
        h_in_tag.wy        = wy_reg;
    end

    fvn_hash u_hash (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (h_in_valid),
        .xi        (h_xi),
        .yi        (h_yi),
        .row       (row),
        .in_tag    (h_in_tag),
        .out_valid (h_valid),
        .value     (h_value),
        .out_tag   (h_tag)
    );

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || result.ready);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (q_valid)
                    state_next = (q_item.oct_n == '0) ? ST_OUT : ST_SETUP;
            end
            ST_SETUP: state_next = ST_ISSUE;
            ST_ISSUE:
            begin
                if (j_reg == 4'd15)
                    state_next = (k_reg == n_reg - OCT_NW'(1)) ? ST_DRAIN : ST_SETUP;
            end
            ST_DRAIN:
            begin
                if (done_reg)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // sequencer payload
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg   <= q_item.x;
            y_reg   <= q_item.y;
            n_reg   <= q_item.oct_n;
            set_reg <= q_item.set0;
            k_reg   <= '0;
        end
        if (state_reg == ST_SETUP)
        begin
            cx_reg <= x_reg[31] ? (32'd0 - ip_x) : ip_x;
            cy_reg <= y_reg[31] ? (32'd0 - ip_y) : ip_y;
            wx_reg <= cos_lut[fr_x[COS_TABLE_BITS-1:0]];
            wy_reg <= cos_lut[fr_y[COS_TABLE_BITS-1:0]];
            j_reg  <= 4'd0;
        end
        if (state_reg == ST_ISSUE)
        begin
            j_reg <= j_reg + 4'd1;
            if (j_reg == 4'd15)
            begin
                k_reg <= k_reg + OCT_NW'(1);
                // advance the prime set, wrapping at the set count
                if (5'(set_reg) == 5'(PRIME_SETS - 1))
                    set_reg <= '0;
                else
                    set_reg <= set_reg + SET_NW'(1);
            end
        end
    end

    // lattice grid and finisher datapath
    assign amp_mul = amp_reg * amplitude_ratio;

    always_ff @(posedge clk)
    begin
        if (h_valid)
            grid_reg[h_tag.pos] <= h_value;
        if (h_valid && h_tag.last)
        begin
            fwx_reg <= h_tag.wx;
            fwy_reg <= h_tag.wy;
            fin_reg <= h_tag.final_oct;
        end
        if (go_reg)
        begin
            sm_reg[0] <= smooth(grid_reg, 0, 0);
            sm_reg[1] <= smooth(grid_reg, 1, 0);
            sm_reg[2] <= smooth(grid_reg, 0, 1);
            sm_reg[3] <= smooth(grid_reg, 1, 1);
        end
        if (f1_valid_reg)
        begin
            bx0_reg <= blend(sm_reg[0], sm_reg[1], fwx_reg);
            bx1_reg <= blend(sm_reg[2], sm_reg[3], fwx_reg);
        end
        if (f2_valid_reg)
            v_reg <= blend(bx0_reg, bx1_reg, fwy_reg);
        if (start)
            amp_reg <= AMP_W'(32768);
        else if (f2_valid_reg)
            amp_reg <= AMP_W'(amp_mul >> 15);
        if (f3_valid_reg)
            prod_reg <= PROD_W'(v_reg) * $signed({1'b0, amp_reg});
        if (start)
            acc_reg <= '0;
        else if (f4_valid_reg)
            acc_reg <= acc_reg + ACC_W'(prod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            go_reg        <= 1'b0;
            f1_valid_reg  <= 1'b0;
            f2_valid_reg  <= 1'b0;
            f3_valid_reg  <= 1'b0;
            f4_valid_reg  <= 1'b0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            go_reg       <= h_valid && h_tag.last;
            f1_valid_reg <= go_reg;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
            f4_valid_reg <= f3_valid_reg;
            done_reg     <= f4_valid_reg && fin_reg;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (result.ready)
                out_valid_reg <= 1'b0;
        end
    end

    // floor to Q4.16 and saturate
    always_comb
    begin
        r_full = R_W'(acc_reg >>> 15);
        if (r_full > R_MAX)
            r_sat = OUT_W'(R_MAX);
        else if (r_full < R_MIN)
            r_sat = OUT_W'(R_MIN);
        else
            r_sat = OUT_W'(r_full);
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            out_data_reg <= r_sat;
    end

    assign result.valid       = out_valid_reg;
    assign result.noise_value = out_data_reg;

endmodule

// ===== rtl/core/fractal_value_noise_2d.sv =====
// Fractal value noise at a signed Q16.16 point, summed over up to MAX_OCTAVES
// octaves and saturated to signed Q4.16. One shared four-stage hash pipeline
// produces one lattice hash per cycle in the issue state; each octave needs
// 16 hashes after a setup state. A two-entry queue takes new items while one
// is computed, and the result register lets the next item start while a
// result waits. Config is written through cfg_write/cfg_index/cfg_data; the
// user must do so only while the block is idle, as the block does not
// enforce it. Unknown indexes are ignored. No clearing pass.
module fractal_value_noise_2d #(
    parameter int MAX_OCTAVES    = 8,
    parameter int PRIME_SETS     = 10,
    parameter int COS_TABLE_BITS = 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    fvn_sample_if.sink                        sample,
    fvn_result_if.source                      result,
    input  logic                              cfg_write,
    input  logic [fvn_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [fvn_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import fvn_pkg::*;

    logic [3:0]  octave_count_reg;
    logic [15:0] amplitude_ratio_reg;
    logic [3:0]  prime_set_start_reg;
    logic        q_valid;
    job_t        q_item;
    logic        q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            octave_count_reg    <= RST_OCTAVE_COUNT;
            amplitude_ratio_reg <= RST_AMPLITUDE_RATIO;
            prime_set_start_reg <= RST_PRIME_SET_START;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_OCTAVE_COUNT:    octave_count_reg    <= cfg_data[3:0];
                CFG_AMPLITUDE_RATIO: amplitude_ratio_reg <= cfg_data;
                CFG_PRIME_SET_START: prime_set_start_reg <= cfg_data[3:0];
                default:             ;
            endcase
        end
    end

    fvn_front #(
        .MAX_OCTAVES (MAX_OCTAVES),
        .PRIME_SETS  (PRIME_SETS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .sample          (sample),
        .octave_count    (octave_count_reg),
        .prime_set_start (prime_set_start_reg),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop)
    );

    fvn_back #(
        .MAX_OCTAVES    (MAX_OCTAVES),
        .PRIME_SETS     (PRIME_SETS),
        .COS_TABLE_BITS (COS_TABLE_BITS)
    ) u_back (
        .clk             (clk),
        .rst_n           (rst_n),
        .q_valid         (q_valid),
        .q_item          (q_item),
        .q_pop           (q_pop),
        .amplitude_ratio (amplitude_ratio_reg),
        .result          (result)
    );

endmodule

// ===== tb/sv/fvn_noise_scoreboard.sv =====
// Scoreboard for the fractal value noise testbench: predicts the noise at each
// accepted point and checks results in order. Depends on fvn_pkg only.
`timescale 1ns / 1ps

class fvn_noise_scoreboard;

    // prime triples of the hash, one row per set
    static const logic [31:0] HASH_PRIMES [10][3] = '{
        '{32'd995615039, 32'd600173719, 32'd701464987},
        '{32'd831731269, 32'd162318869, 32'd136250887},
        '{32'd174329291, 32'd946737083, 32'd245679977},
        '{32'd362489573, 32'd795918041, 32'd350777237},
        '{32'd457025711, 32'd880830799, 32'd909678923},
        '{32'd787070341, 32'd177340217, 32'd593320781},
        '{32'd405493717, 32'd291031019, 32'd391950901},
        '{32'd458904767, 32'd676625681, 32'd424452397},
        '{32'd531736441, 32'd939683957, 32'd810651871},
        '{32'd997169939, 32'd842027887, 32'd423882827}
    };
    localparam int MAX_OCT = 8;
    localparam int NUM_SETS = 10;
    localparam int WBITS = 8;

    logic [3:0]         octaves;
    logic [15:0]        ratio;
    logic [3:0]         set_start;
    logic signed [19:0] pending_noise [$];
    int                 mismatches;
    int                 checked;

    function new();
        octaves = 4'd7;
        ratio = 16'd16384;
        set_start = 4'd0;
        mismatches = 0;
        checked = 0;
    endfunction

    function void set_register(logic [1:0] idx, logic [15:0] data);
        case (idx)
            fvn_pkg::CFG_OCTAVE_COUNT:    octaves = data[3:0];
            fvn_pkg::CFG_AMPLITUDE_RATIO: ratio = data;
            fvn_pkg::CFG_PRIME_SET_START: set_start = data[3:0];
            default: ;
        endcase
    endfunction

    static function longint floor_div(longint v, int s);
        return v >>> s;
    endfunction

    static function longint node_value(int row, logic [31:0] xi, logic [31:0] yi);
        logic [31:0] n;
        logic [31:0] t;
        n = xi + yi * 32'd57;
        n = (n << 13) ^ n;
        t = (n * (n * n * HASH_PRIMES[row][0] + HASH_PRIMES[row][1])
             + HASH_PRIMES[row][2]) & 32'h7fffffff;
        return 65536 - longint'(t >> 14);
    endfunction

    static function longint smooth_value(int row, logic [31:0] x, logic [31:0] y);
        longint c;
        longint s;
        c = node_value(row, x - 1, y - 1) + node_value(row, x + 1, y - 1)
            + node_value(row, x - 1, y + 1) + node_value(row, x + 1, y + 1);
        s = node_value(row, x - 1, y) + node_value(row, x + 1, y)
            + node_value(row, x, y - 1) + node_value(row, x, y + 1);
        return floor_div(c + 2 * s + 4 * node_value(row, x, y), 4);
    endfunction

    static function longint taylor_weight(longint idx);
        longint unsigned th;
        longint unsigned p2;
        longint unsigned p4;
        longint unsigned p6;
        longint unsigned p8;
        longint unsigned p10;
        longint          v;
        th = (64'd3373259426 * idx) >> WBITS;
        p2 = (th * th) >> 30;
        p4 = (p2 * p2) >> 30;
        p6 = (p4 * p2) >> 30;
        p8 = (p6 * p2) >> 30;
        p10 = (p8 * p2) >> 30;
        v = longint'(p2 / 2) - longint'(p4 / 24) + longint'(p6 / 720)
            - longint'(p8 / 40320) + longint'(p10 / 3628800);
        if (v < 0)
            v = 0;
        return (v + 16384) >>> 15;
    endfunction

    static function longint blend_weight(longint idx);
        if (idx <= (1 << (WBITS - 1)))
            return taylor_weight(idx);
        return 65536 - taylor_weight((1 << WBITS) - idx);
    endfunction

    static function longint lerp(longint a, longint b, longint w);
        return a + floor_div((b - a) * w, 16);
    endfunction

    // split a coordinate into lattice point and weight index by magnitude
    static function void split_coord(logic [31:0] raw, int sh,
                                     output logic [31:0] lat, output longint idx);
        logic [32:0] mag;
        logic [31:0] ip;
        mag = raw[31] ? (33'h1_0000_0000 - {1'b0, raw}) : {1'b0, raw};
        ip = 32'(mag >> sh);
        lat = raw[31] ? (32'd0 - ip) : ip;
        idx = longint'((mag & ((33'd1 << sh) - 1)) >> (sh - WBITS));
    endfunction

    function logic signed [19:0] noise_at(logic [31:0] xr, logic [31:0] yr);
        int                n;
        int                sh;
        int                row;
        longint unsigned   amp;
        longint            total;
        longint            wx;
        longint            wy;
        longint            ix;
        longint            iy;
        longint            v;
        longint            r;
        logic [31:0]       cx;
        logic [31:0]       cy;
        n = (octaves > MAX_OCT) ? MAX_OCT : octaves;
        amp = 32768;
        total = 0;
        for (int k = 0; k < n; k++)
        begin
            sh = 16 + (n - 1 - k);
            row = (int'(set_start) + k) % NUM_SETS;
            split_coord(xr, sh, cx, ix);
            split_coord(yr, sh, cy, iy);
            wx = blend_weight(ix);
            wy = blend_weight(iy);
            v = lerp(lerp(smooth_value(row, cx, cy), smooth_value(row, cx + 1, cy), wx),
                     lerp(smooth_value(row, cx, cy + 1),
                          smooth_value(row, cx + 1, cy + 1), wx), wy);
            amp = (amp * ratio) >> 15;
            total += v * longint'(amp);
        end
        r = floor_div(total, 15);
        if (r > 524287)
            r = 524287;
        if (r < -524288)
            r = -524288;
        return 20'(r);
    endfunction

    function void note_sample(logic [31:0] xr, logic [31:0] yr);
        pending_noise.push_back(noise_at(xr, yr));
    endfunction

    task report(string what);
        mismatches++;
        $display("mismatch: %s", what);
    endtask

    task check_noise(logic signed [19:0] got);
        logic signed [19:0] want;
        checked++;
        if (pending_noise.size() == 0)
        begin
            report($sformatf("unexpected result %0d", got));
            return;
        end
        want = pending_noise.pop_front();
        if (got !== want)
            report($sformatf("noise_value got %0d want %0d", got, want));
    endtask

endclass

// ===== tb/sv/fractal_value_noise_2d_test.sv =====
// Top of the fractal value noise testbench: drives points and config writes, stalls
// both channels at random. Depends on fvn_pkg, fvn_if, the scoreboard and the DUT.
`timescale 1ns / 1ps

module fractal_value_noise_2d_test;

    import fvn_pkg::*;

    localparam logic [1:0] CFG_UNUSED_INDEX = 2'd3;

    logic        clk;
    logic        rst_n;
    logic        cfg_write;
    logic [1:0]  cfg_index;
    logic [15:0] cfg_data;
    logic        calm;
    int          hold_cycles;
    int          sent;

    fvn_sample_if sample ();
    fvn_result_if result ();
    fvn_noise_scoreboard board;

    fractal_value_noise_2d u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample    (sample),
        .result    (result),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    initial
    begin
        #200_000_000;
        $display("fractal_value_noise_2d_test NOT OK");
        $finish;
    end

    // result side: random stalls, plus one long hold-off on request
    initial
    begin
        result.ready = 1'b0;
        @(posedge clk iff rst_n);
        forever
        begin
            if (hold_cycles > 0)
            begin
                result.ready <= 1'b0;
                repeat (hold_cycles) @(posedge clk);
                hold_cycles = 0;
            end
            else if (!calm && $urandom_range(0, 3) == 0)
            begin
                result.ready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(posedge clk);
            end
            else
            begin
                result.ready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && result.valid && result.ready)
            board.check_noise(result.noise_value);
    end

    // valid stays high after an accept so that items can follow back to back
    task automatic send_point(logic [31:0] xv, logic [31:0] yv);
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            sample.valid <= 1'b0;
            repeat ($urandom_range(1, 13)) @(posedge clk);
        end
        sample.valid <= 1'b1;
        sample.x_coord <= xv;
        sample.y_coord <= yv;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        board.note_sample(xv, yv);
        sent++;
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        board.set_register(idx, data);
        @(posedge clk);
    endtask

    // drop valid and wait for every outstanding item to drain before touching config
    task automatic drain();
        int guard;
        sample.valid <= 1'b0;
        guard = 0;
        while (board.pending_noise.size() != 0 && guard < 200_000)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (200) @(posedge clk);
    endtask

    function automatic logic [31:0] random_coord();
        case ($urandom_range(0, 3))
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 2_000_000)) - 1_000_000);
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom)};
            default: return 32'($signed($urandom_range(0, 40_000)) - 20_000);
        endcase
    endfunction

    task automatic random_points(int count);
        for (int i = 0; i < count; i++)
            send_point(random_coord(), random_coord());
    endtask

    initial
    begin
        logic [31:0] corner [6];
        board = new();
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_index = CFG_OCTAVE_COUNT;
        cfg_data = 16'd0;
        sample.valid = 1'b0;
        sample.x_coord = 32'd0;
        sample.y_coord = 32'd0;
        calm = 1'b0;
        hold_cycles = 0;
        sent = 0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: field extremes, negatives, cell edges, most negative value
        corner = '{32'h8000_0000, 32'h7fff_ffff, 32'h0, 32'hffff_ffff,
                   32'hffff_0000, 32'h0001_8000};
        for (int i = 0; i < 6; i++)
            send_point(corner[i], corner[5 - i]);
        for (int i = 0; i < 6; i++)
            send_point(corner[i], corner[i]);
        drain();

        // more octaves than supported, odd start index, full ratio
        write_reg(CFG_OCTAVE_COUNT, 16'd15);
        write_reg(CFG_AMPLITUDE_RATIO, 16'hffff);
        write_reg(CFG_PRIME_SET_START, 16'd15);
        write_reg(CFG_UNUSED_INDEX, 16'h1234);
        send_point(32'h8000_0000, 32'h7fff_ffff);
        send_point(32'h0000_4000, 32'hffff_c000);
        random_points(4);
        drain();
        write_reg(CFG_OCTAVE_COUNT, 16'd0);
        write_reg(CFG_AMPLITUDE_RATIO, 16'd0);
        send_point(32'h1234_5678, 32'h8765_4321);
        send_point(32'h0, 32'h0);
        drain();

        // random phases over settings, with one long result hold-off
        for (int ph = 0; ph < 10; ph++)
        begin
            write_reg(CFG_OCTAVE_COUNT, 16'($urandom_range(0, 15)));
            write_reg(CFG_AMPLITUDE_RATIO, ph[0] ? 16'($urandom) : 16'd32768);
            write_reg(CFG_PRIME_SET_START, 16'($urandom_range(0, 15)));
            if (ph == 3)
                hold_cycles = 2000;
            if (ph == 9)
                calm = 1'b1;
            random_points(78);
            drain();
        end

        $display("covered %0d points over random octave counts, ratios and prime starts",
                 sent);
        $display("checked %0d results, %0d mismatches", board.checked, board.mismatches);
        if (board.mismatches == 0 && board.pending_noise.size() == 0)
            $display("fractal_value_noise_2d_test OK");
        else
            $display("fractal_value_noise_2d_test NOT OK");
        $finish;
    end

endmodule
